// ===== rtl/h264rtp_pkg.sv =====
// ----------------------------------------------------------------------------
// h264rtp_pkg
// Shared constants and types of the H.264 RTP packetizer.
// ----------------------------------------------------------------------------
package h264rtp_pkg;

  localparam int LEN_BITS = 20;

  localparam int PAY_W   = 13;
  localparam int SEQ_W   = 16;
  localparam int STAMP_W = 32;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_MAX_PAYLOAD = 2'd0;
  localparam logic [IDX_W-1:0] REG_STAMP_STEP  = 2'd1;
  localparam logic [IDX_W-1:0] REG_FIRST_SEQ   = 2'd2;
  localparam logic [IDX_W-1:0] REG_FIRST_STAMP = 2'd3;

  localparam logic [PAY_W-1:0]   RST_MAX_PAYLOAD = 13'd1400;
  localparam logic [STAMP_W-1:0] RST_STAMP_STEP  = 32'd3600;
  localparam logic [SEQ_W-1:0]   RST_FIRST_SEQ   = 16'd0;
  localparam logic [STAMP_W-1:0] RST_FIRST_STAMP = 32'd0;

  localparam logic [PAY_W-1:0] PAY_MIN = 13'd16;
  localparam logic [PAY_W-1:0] PAY_MAX = 13'd4096;

  localparam logic [7:0] FU_A_TYPE = 8'd28;
  localparam logic [7:0] NRI_MASK  = 8'h60;
  localparam logic [7:0] TYPE_MASK = 8'h1F;
  localparam logic [7:0] S_BIT     = 8'h80;
  localparam logic [7:0] E_BIT     = 8'h40;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               packet_first;
    logic               packet_last;
    logic [SEQ_W-1:0]   seq_no;
    logic [STAMP_W-1:0] time_stamp;
    logic               fragmented;
    logic               run_end;
  } word_t;

  typedef struct packed {
    logic [PAY_W-1:0]   pay;
    logic [STAMP_W-1:0] step;
    logic               seq_load;
    logic [SEQ_W-1:0]   seq_value;
    logic               stamp_load;
    logic [STAMP_W-1:0] stamp_value;
  } cfg_t;

  typedef struct packed {
    logic            load;
    logic [1:0]      cnt;
    word_t [2:0]     words;
  } load_t;

endpackage

// ===== rtl/h264rtp_in_if.sv =====
// ----------------------------------------------------------------------------
// h264rtp_in_if
// NAL byte channel: valid/ready handshake with byte, begin flag and length.
// ----------------------------------------------------------------------------
interface h264rtp_in_if #(
  parameter int LEN_BITS = h264rtp_pkg::LEN_BITS
);
  logic                valid;
  logic                ready;
  logic [7:0]          nal_byte;
  logic                nal_begin;
  logic [LEN_BITS-1:0] nal_length;

  modport source (output valid, nal_byte, nal_begin, nal_length, input ready);
  modport sink   (input valid, nal_byte, nal_begin, nal_length, output ready);
endinterface

// ===== rtl/h264rtp_out_if.sv =====
// ----------------------------------------------------------------------------
// h264rtp_out_if
// Packet payload channel: valid/ready handshake with one payload byte and
// its packet marks.
// ----------------------------------------------------------------------------
interface h264rtp_out_if;
  logic                                valid;
  logic                                ready;
  logic [7:0]                          out_byte;
  logic                                packet_first;
  logic                                packet_last;
  logic [h264rtp_pkg::SEQ_W-1:0]       seq_no;
  logic [h264rtp_pkg::STAMP_W-1:0]     time_stamp;
  logic                                fragmented;
  logic                                run_end;

  modport source (output valid, out_byte, packet_first, packet_last, seq_no,
                  time_stamp, fragmented, run_end, input ready);
  modport sink   (input valid, out_byte, packet_first, packet_last, seq_no,
                  time_stamp, fragmented, run_end, output ready);
endinterface

// ===== rtl/h264_rtp_fragmenter.sv =====
// ----------------------------------------------------------------------------
// h264_rtp_fragmenter
// H.264 RTP packetizer: single NAL unit packets and FU-A fragments.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | word
//  nal      | in  | valid/ready     | nal_byte, nal_begin, nal_length
//  pkt      | out | valid/ready     | out_byte, marks, seq_no, time_stamp
//  cfg      | in  | cfg_we          | cfg_index, cfg_data (write only)
//
//  One NAL byte per cycle unless the output stalls. The byte that opens a
//  fragment leaves as three words (indicator, FU header, data); the input
//  waits for the bank. Stages: input register, three-word result bank.
//  Reset is synchronous; it clears control state and loads register defaults.
//  A stalled output holds the bank; the input register refills as it drains.
// ----------------------------------------------------------------------------
module h264_rtp_fragmenter #(
  parameter int LEN_BITS = h264rtp_pkg::LEN_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  h264rtp_in_if.sink                     nal,
  h264rtp_out_if.source                  pkt,
  input  logic                           cfg_we,
  input  logic [h264rtp_pkg::IDX_W-1:0]  cfg_index,
  input  logic [h264rtp_pkg::CFG_W-1:0]  cfg_data
);

  h264rtp_pkg::cfg_t  cfg;
  h264rtp_pkg::load_t ld;
  logic               free;

  h264rtp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  h264rtp_core #(
    .LEN_BITS (LEN_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .nal  (nal),
    .cfg  (cfg),
    .free (free),
    .ld   (ld)
  );

  h264rtp_outq u_outq (
    .clk  (clk),
    .rst  (rst),
    .ld   (ld),
    .free (free),
    .pkt  (pkt)
  );

endmodule

// ===== rtl/h264rtp_cfg.sv =====
// ----------------------------------------------------------------------------
// h264rtp_cfg
// Configuration registers: clamped payload limit, timestamp step, and load
// strobes for the sequence and timestamp counters.
// ----------------------------------------------------------------------------
module h264rtp_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [h264rtp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [h264rtp_pkg::CFG_W-1:0]   cfg_data,
  output h264rtp_pkg::cfg_t               cfg
);

  logic [h264rtp_pkg::PAY_W-1:0]   pay;
  logic [h264rtp_pkg::STAMP_W-1:0] step;
  logic [h264rtp_pkg::PAY_W-1:0]   pay_raw;
  logic [h264rtp_pkg::PAY_W-1:0]   pay_clamp;

  assign pay_raw = cfg_data[h264rtp_pkg::PAY_W-1:0];

  always_comb begin
    if (pay_raw < h264rtp_pkg::PAY_MIN) begin
      pay_clamp = h264rtp_pkg::PAY_MIN;
    end else if (pay_raw > h264rtp_pkg::PAY_MAX) begin
      pay_clamp = h264rtp_pkg::PAY_MAX;
    end else begin
      pay_clamp = pay_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pay  <= h264rtp_pkg::RST_MAX_PAYLOAD;
      step <= h264rtp_pkg::RST_STAMP_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        h264rtp_pkg::REG_MAX_PAYLOAD: pay  <= pay_clamp;
        h264rtp_pkg::REG_STAMP_STEP:  step <= cfg_data[h264rtp_pkg::STAMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.pay         = pay;
  assign cfg.step        = step;
  assign cfg.seq_load    = cfg_we && (cfg_index == h264rtp_pkg::REG_FIRST_SEQ);
  assign cfg.seq_value   = cfg_data[h264rtp_pkg::SEQ_W-1:0];
  assign cfg.stamp_load  = cfg_we && (cfg_index == h264rtp_pkg::REG_FIRST_STAMP);
  assign cfg.stamp_value = cfg_data[h264rtp_pkg::STAMP_W-1:0];

endmodule

// ===== rtl/h264rtp_core.sv =====
// ----------------------------------------------------------------------------
// h264rtp_core
// Input register and packetizer state. Turns one NAL byte into zero, one or three
// payload words (FU indicator, FU header, data) in a single pass.
// ----------------------------------------------------------------------------
module h264rtp_core #(
  parameter int LEN_BITS = h264rtp_pkg::LEN_BITS
) (
  input  logic                clk,
  input  logic                rst,
  h264rtp_in_if.sink          nal,
  input  h264rtp_pkg::cfg_t   cfg,
  input  logic                free,
  output h264rtp_pkg::load_t  ld
);

  localparam int PAY_W = h264rtp_pkg::PAY_W;
  localparam int CW    = ((LEN_BITS > PAY_W) ? LEN_BITS : PAY_W) + 1;

  logic                ir_v;
  logic [7:0]          ir_byte;
  logic                ir_begin;
  logic [LEN_BITS-1:0] ir_len;

  logic                                frag_mode, frag_mode_next;
  logic [7:0]                          nal_header, nal_header_next;
  logic [LEN_BITS-1:0]                 bytes_left, bytes_left_next;
  logic [PAY_W-1:0]                    fill, fill_next;
  logic                                first_frag, first_frag_next;
  logic [h264rtp_pkg::SEQ_W-1:0]       seq_count, seq_count_next;
  logic [h264rtp_pkg::STAMP_W-1:0]     stamp_now, stamp_now_next;

  logic                            consume;
  logic [LEN_BITS-1:0]             len0;
  logic [CW-1:0]                   len_w, rem_w, m_w;
  logic                            abandon, close_ab, fits, one;
  logic                            rem_one, rem_two, is_last, close_d;
  logic [PAY_W:0]                  f1, m14;
  logic [7:0]                      ind_byte, fu_byte;
  logic [1:0]                      seq_inc, stamp_sel;
  logic                            out_seq_inc, out_adv;
  logic [h264rtp_pkg::SEQ_W-1:0]   out_seq;
  logic [h264rtp_pkg::STAMP_W-1:0] out_stamp, stamp_add;
  logic [1:0]                      cnt;
  logic [7:0]                      b0, b1;
  logic                            pf0, pl0, fr, pl2;
  logic [1:0]                      shape;

  localparam logic [1:0] SHAPE_NONE  = 2'd0;
  localparam logic [1:0] SHAPE_ONE   = 2'd1;
  localparam logic [1:0] SHAPE_THREE = 2'd2;

  assign consume   = ir_v && free;
  assign nal.ready = !ir_v || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_v <= 1'b0;
    end else if (nal.ready) begin
      ir_v <= nal.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (nal.ready && nal.valid) begin
      ir_byte  <= nal.nal_byte;
      ir_begin <= nal.nal_begin;
      ir_len   <= nal.nal_length;
    end
  end

  assign len0     = (ir_len == '0) ? LEN_BITS'(1) : ir_len;
  assign len_w    = CW'(len0);
  assign rem_w    = CW'(bytes_left);
  assign m_w      = CW'(cfg.pay);
  assign abandon  = (bytes_left != '0);
  assign close_ab = abandon && (!frag_mode || (fill != '0));
  assign fits     = (len_w <= m_w);
  assign one      = (len0 == LEN_BITS'(1));
  assign rem_one  = (bytes_left == LEN_BITS'(1));
  assign rem_two  = (bytes_left == LEN_BITS'(2));
  assign f1       = {1'b0, fill} + (PAY_W+1)'(1);
  assign m14      = {1'b0, cfg.pay};
  assign is_last  = (rem_w <= m_w) && !(first_frag && (rem_w == m_w));
  assign close_d  = (f1 >= m14) || rem_one ||
                    (first_frag && (f1 == m14 - (PAY_W+1)'(1)) && rem_two);
  assign ind_byte = (nal_header & h264rtp_pkg::NRI_MASK) | h264rtp_pkg::FU_A_TYPE;
  assign fu_byte  = (nal_header & h264rtp_pkg::TYPE_MASK) |
                    (first_frag ? h264rtp_pkg::S_BIT : 8'h00) |
                    (is_last ? h264rtp_pkg::E_BIT : 8'h00);

  always_comb begin
    frag_mode_next  = frag_mode;
    nal_header_next = nal_header;
    bytes_left_next = bytes_left;
    fill_next       = fill;
    first_frag_next = first_frag;
    seq_inc         = 2'd0;
    stamp_sel       = 2'd0;
    out_seq_inc     = 1'b0;
    out_adv         = 1'b0;
    shape           = SHAPE_NONE;
    b0              = ir_byte;
    b1              = fu_byte;
    pf0             = 1'b0;
    pl0             = 1'b0;
    pl2             = close_d;
    fr              = 1'b0;
    if (ir_begin) begin
      out_adv         = abandon;
      out_seq_inc     = close_ab;
      nal_header_next = ir_byte;
      bytes_left_next = len0 - LEN_BITS'(1);
      fill_next       = '0;
      first_frag_next = 1'b1;
      seq_inc         = {1'b0, close_ab};
      stamp_sel       = {1'b0, abandon};
      if (fits) begin
        frag_mode_next = 1'b0;
        shape          = SHAPE_ONE;
        pf0            = 1'b1;
        pl0            = one;
        if (one) begin
          seq_inc   = {1'b0, close_ab} + 2'd1;
          stamp_sel = {1'b0, abandon} + 2'd1;
        end else begin
          fill_next = PAY_W'(1);
        end
      end else begin
        frag_mode_next = 1'b1;
      end
    end else if (abandon) begin
      bytes_left_next = bytes_left - LEN_BITS'(1);
      if (!frag_mode) begin
        shape = SHAPE_ONE;
        pl0   = rem_one;
        if (rem_one) begin
          seq_inc   = 2'd1;
          stamp_sel = 2'd1;
          fill_next = '0;
        end
      end else begin
        fr        = 1'b1;
        fill_next = f1[PAY_W-1:0];
        if (fill == '0) begin
          shape = SHAPE_THREE;
          b0    = ind_byte;
          pf0   = 1'b1;
        end else begin
          shape = SHAPE_ONE;
          pl0   = close_d;
        end
        if (close_d) begin
          seq_inc         = 2'd1;
          fill_next       = '0;
          first_frag_next = 1'b0;
          if (rem_one) begin
            stamp_sel = 2'd1;
          end
        end
      end
    end
  end

  always_comb begin
    case (stamp_sel)
      2'd1:    stamp_add = cfg.step;
      2'd2:    stamp_add = {cfg.step[h264rtp_pkg::STAMP_W-2:0], 1'b0};
      default: stamp_add = '0;
    endcase
  end

  assign out_seq        = seq_count + h264rtp_pkg::SEQ_W'(out_seq_inc);
  assign out_stamp      = stamp_now + (out_adv ? cfg.step : '0);
  assign seq_count_next = seq_count + h264rtp_pkg::SEQ_W'(seq_inc);
  assign stamp_now_next = stamp_now + stamp_add;

  always_comb begin
    ld.load = consume;
    cnt     = 2'd0;
    for (int i = 0; i < 3; i++) begin
      ld.words[i].out_byte     = ir_byte;
      ld.words[i].packet_first = 1'b0;
      ld.words[i].packet_last  = 1'b0;
      ld.words[i].seq_no       = out_seq;
      ld.words[i].time_stamp   = out_stamp;
      ld.words[i].fragmented   = fr;
      ld.words[i].run_end      = 1'b0;
    end
    ld.words[0].out_byte     = b0;
    ld.words[0].packet_first = pf0;
    ld.words[0].packet_last  = pl0;
    ld.words[1].out_byte     = b1;
    ld.words[2].packet_last  = pl2;
    case (shape)
      SHAPE_ONE: begin
        cnt                 = 2'd1;
        ld.words[0].run_end = 1'b1;
      end
      SHAPE_THREE: begin
        cnt                 = 2'd3;
        ld.words[2].run_end = 1'b1;
      end
      default: cnt = 2'd0;
    endcase
    ld.cnt = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frag_mode  <= 1'b0;
      nal_header <= '0;
      bytes_left <= '0;
      fill       <= '0;
      first_frag <= 1'b0;
      seq_count  <= h264rtp_pkg::RST_FIRST_SEQ;
      stamp_now  <= h264rtp_pkg::RST_FIRST_STAMP;
    end else begin
      if (consume) begin
        frag_mode  <= frag_mode_next;
        nal_header <= nal_header_next;
        bytes_left <= bytes_left_next;
        fill       <= fill_next;
        first_frag <= first_frag_next;
      end
      if (cfg.seq_load) begin
        seq_count <= cfg.seq_value;
      end else if (consume) begin
        seq_count <= seq_count_next;
      end
      if (cfg.stamp_load) begin
        stamp_now <= cfg.stamp_value;
      end else if (consume) begin
        stamp_now <= stamp_now_next;
      end
    end
  end

endmodule

// ===== rtl/h264rtp_outq.sv =====
// ----------------------------------------------------------------------------
// h264rtp_outq
// Result bank: holds up to three payload words of one input byte and shifts
// them out one word per cycle while the output is ready.
// ----------------------------------------------------------------------------
module h264rtp_outq (
  input  logic                clk,
  input  logic                rst,
  input  h264rtp_pkg::load_t  ld,
  output logic                free,
  h264rtp_out_if.source       pkt
);

  h264rtp_pkg::word_t [2:0] bank;
  logic [1:0]               n;
  logic                     pop;

  assign pop  = (n != 2'd0) && pkt.ready;
  assign free = (n == 2'd0) || ((n == 2'd1) && pkt.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= 2'd0;
    end else if (ld.load) begin
      n <= ld.cnt;
    end else if (pop) begin
      n <= n - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      bank <= ld.words;
    end else if (pop) begin
      bank[0] <= bank[1];
      bank[1] <= bank[2];
    end
  end

  assign pkt.valid        = (n != 2'd0);
  assign pkt.out_byte     = bank[0].out_byte;
  assign pkt.packet_first = bank[0].packet_first;
  assign pkt.packet_last  = bank[0].packet_last;
  assign pkt.seq_no       = bank[0].seq_no;
  assign pkt.time_stamp   = bank[0].time_stamp;
  assign pkt.fragmented   = bank[0].fragmented;
  assign pkt.run_end      = bank[0].run_end;

endmodule

// ===== rtl/h264rtp_check.sv =====
// ----------------------------------------------------------------------------
// h264rtp_check
// Port-level checks of the packet payload channel.
// ----------------------------------------------------------------------------
module h264rtp_check (
  input logic       clk,
  input logic       rst,
  input logic       pkt_valid,
  input logic       pkt_ready,
  input logic [7:0] pkt_byte,
  input logic       pkt_first,
  input logic       pkt_frag,
  input logic       pkt_run_end
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !pkt_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt_byte))
    else $error("stalled word changed");

  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_ready && !pkt_run_end |=> pkt_valid)
    else $error("gap inside the words of one byte");

  a_fu_ind: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_frag && pkt_first |->
      ((pkt_byte & h264rtp_pkg::TYPE_MASK) == h264rtp_pkg::FU_A_TYPE) && !pkt_run_end)
    else $error("bad FU indicator word");

  a_single: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && !pkt_frag && pkt_first |-> pkt_run_end)
    else $error("single NAL first word not last of its run");

endmodule

bind h264_rtp_fragmenter h264rtp_check u_check (
  .clk         (clk),
  .rst         (rst),
  .pkt_valid   (pkt.valid),
  .pkt_ready   (pkt.ready),
  .pkt_byte    (pkt.out_byte),
  .pkt_first   (pkt.packet_first),
  .pkt_frag    (pkt.fragmented),
  .pkt_run_end (pkt.run_end)
);
